// ===== src/crr_pkg.sv =====
`timescale 1ns / 1ps

package crr_pkg;

  // Width of the sub-second accumulator and the count at which it rolls over into a new second.
  localparam int unsigned SUB_W = 23;
  localparam int unsigned SUM_W = SUB_W + 1;
  localparam logic [SUM_W-1:0] TICKS_PER_SECOND = 24'd4194304;
  localparam logic [SUB_W-1:0] SUB_MAX = {SUB_W{1'b1}};

  localparam logic [7:0] READ_IDLE = 8'hFF;

  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_SET_ENABLE = 3'd1,
    FUNC_SELECT     = 3'd2,
    FUNC_UNSELECT   = 3'd3,
    FUNC_LATCH      = 3'd4,
    FUNC_WRITE      = 3'd5,
    FUNC_READ       = 3'd6
  } func_e;

  typedef enum logic [3:0] {
    REG_NONE     = 4'd0,
    REG_SECONDS  = 4'd8,
    REG_MINUTES  = 4'd9,
    REG_HOURS    = 4'd10,
    REG_DAY_LOW  = 4'd11,
    REG_DAY_HIGH = 4'd12
  } reg_sel_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic [7:0] cycles;
  } item_t;

  typedef struct packed {
    logic       is_enabled;
    logic       is_selected;
    logic [7:0] read_data;
  } result_t;

endpackage

// ===== src/crr_core.sv =====
`timescale 1ns / 1ps

module crr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  crr_pkg::item_t   item_i,
  output crr_pkg::result_t result_o
);

  logic [5:0] run_sec_q, run_sec_d;
  logic [5:0] run_min_q, run_min_d;
  logic [4:0] run_hr_q, run_hr_d;
  logic [8:0] run_day_q, run_day_d;
  logic [7:0] held_sec_q, held_sec_d;
  logic [7:0] held_min_q, held_min_d;
  logic [7:0] held_hr_q, held_hr_d;
  logic [15:0] held_day_q, held_day_d;
  logic [crr_pkg::SUB_W-1:0] sub_q, sub_d;
  logic halted_q, halted_d;
  logic carry_q, carry_d;
  logic enabled_q, enabled_d;
  crr_pkg::reg_sel_e sel_q, sel_d;
  logic armed_q, armed_d;

  // Tick arithmetic: accumulate cycles and carry one second through the counters.
  logic [crr_pkg::SUM_W-1:0] sum, sum_adj;
  logic [crr_pkg::SUB_W-1:0] sub_tick;
  logic sec_roll;
  logic [5:0] sec_inc, min_inc, sec_adv, min_adv;
  logic [4:0] hr_inc, hr_adv;
  logic [8:0] day_inc, day_adv;
  logic carry_adv;

  always_comb begin
    sum      = {1'b0, sub_q} + crr_pkg::SUM_W'(item_i.cycles);
    sec_roll = (sum >= crr_pkg::TICKS_PER_SECOND);
    sum_adj  = sec_roll ? (sum - crr_pkg::TICKS_PER_SECOND) : sum;
    sub_tick = (sum_adj > crr_pkg::SUM_W'(crr_pkg::SUB_MAX)) ? crr_pkg::SUB_MAX
                                                              : sum_adj[crr_pkg::SUB_W-1:0];

    sec_inc   = run_sec_q + 6'd1;
    min_inc   = run_min_q + 6'd1;
    hr_inc    = run_hr_q + 5'd1;
    day_inc   = run_day_q + 9'd1;
    sec_adv   = sec_inc;
    min_adv   = run_min_q;
    hr_adv    = run_hr_q;
    day_adv   = run_day_q;
    carry_adv = carry_q;
    if (sec_inc == 6'd60) begin
      sec_adv = 6'd0;
      min_adv = min_inc;
      if (min_inc == 6'd60) begin
        min_adv = 6'd0;
        hr_adv  = hr_inc;
        if (hr_inc == 5'd24) begin
          hr_adv  = 5'd0;
          day_adv = day_inc;
          if (day_inc == 9'd0) begin
            carry_adv = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    run_sec_d  = run_sec_q;
    run_min_d  = run_min_q;
    run_hr_d   = run_hr_q;
    run_day_d  = run_day_q;
    held_sec_d = held_sec_q;
    held_min_d = held_min_q;
    held_hr_d  = held_hr_q;
    held_day_d = held_day_q;
    sub_d      = sub_q;
    halted_d   = halted_q;
    carry_d    = carry_q;
    enabled_d  = enabled_q;
    sel_d      = sel_q;
    armed_d    = armed_q;
    result_o.read_data = 8'd0;

    unique case (crr_pkg::func_e'(item_i.func))
      crr_pkg::FUNC_TICK: begin
        if (!halted_q) begin
          sub_d = sub_tick;
          if (sec_roll) begin
            run_sec_d = sec_adv;
            run_min_d = min_adv;
            run_hr_d  = hr_adv;
            run_day_d = day_adv;
            carry_d   = carry_adv;
          end
        end
      end
      crr_pkg::FUNC_SET_ENABLE: begin
        enabled_d = item_i.value[0];
      end
      crr_pkg::FUNC_SELECT: begin
        if (item_i.value >= 8'd8 && item_i.value <= 8'd12) begin
          sel_d = crr_pkg::reg_sel_e'(item_i.value[3:0]);
        end else begin
          sel_d = crr_pkg::REG_NONE;
        end
      end
      crr_pkg::FUNC_UNSELECT: begin
        sel_d = crr_pkg::REG_NONE;
      end
      crr_pkg::FUNC_LATCH: begin
        if (item_i.value == 8'd0) begin
          armed_d = 1'b1;
        end else if (armed_q) begin
          armed_d = 1'b0;
          if (item_i.value == 8'd1) begin
            held_sec_d = {2'b00, run_sec_q};
            held_min_d = {2'b00, run_min_q};
            held_hr_d  = {3'b000, run_hr_q};
            held_day_d = {7'd0, run_day_q};
          end
        end
      end
      crr_pkg::FUNC_WRITE: begin
        if (enabled_q) begin
          unique case (sel_q)
            crr_pkg::REG_SECONDS: begin
              run_sec_d = item_i.value[5:0];
              sub_d     = '0;
            end
            crr_pkg::REG_MINUTES:  run_min_d = item_i.value[5:0];
            crr_pkg::REG_HOURS:    run_hr_d  = item_i.value[4:0];
            crr_pkg::REG_DAY_LOW:  run_day_d = {run_day_q[8], item_i.value};
            crr_pkg::REG_DAY_HIGH: begin
              run_day_d = {item_i.value[0], run_day_q[7:0]};
              halted_d  = item_i.value[6];
              carry_d   = item_i.value[7];
            end
            default: ;
          endcase
        end
      end
      crr_pkg::FUNC_READ: begin
        if (!enabled_q) begin
          result_o.read_data = crr_pkg::READ_IDLE;
        end else begin
          unique case (sel_q)
            crr_pkg::REG_SECONDS:  result_o.read_data = held_sec_q;
            crr_pkg::REG_MINUTES:  result_o.read_data = held_min_q;
            crr_pkg::REG_HOURS:    result_o.read_data = held_hr_q;
            crr_pkg::REG_DAY_LOW:  result_o.read_data = held_day_q[7:0];
            crr_pkg::REG_DAY_HIGH: begin
              result_o.read_data = held_day_q[15:8] | {carry_q, halted_q, 6'd0};
            end
            default: result_o.read_data = crr_pkg::READ_IDLE;
          endcase
        end
      end
      default: ;
    endcase

    result_o.is_selected = (sel_d != crr_pkg::REG_NONE);
    result_o.is_enabled  = enabled_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sec_q  <= '0;
      run_min_q  <= '0;
      run_hr_q   <= '0;
      run_day_q  <= '0;
      held_sec_q <= 8'hFF;
      held_min_q <= 8'hFF;
      held_hr_q  <= 8'hFF;
      held_day_q <= 16'hFFFF;
      sub_q      <= '0;
      halted_q   <= 1'b0;
      carry_q    <= 1'b0;
      enabled_q  <= 1'b0;
      sel_q      <= crr_pkg::REG_NONE;
      armed_q    <= 1'b0;
    end else if (step_i) begin
      run_sec_q  <= run_sec_d;
      run_min_q  <= run_min_d;
      run_hr_q   <= run_hr_d;
      run_day_q  <= run_day_d;
      held_sec_q <= held_sec_d;
      held_min_q <= held_min_d;
      held_hr_q  <= held_hr_d;
      held_day_q <= held_day_d;
      sub_q      <= sub_d;
      halted_q   <= halted_d;
      carry_q    <= carry_d;
      enabled_q  <= enabled_d;
      sel_q      <= sel_d;
      armed_q    <= armed_d;
    end
  end

endmodule

// ===== src/cartridge_rtc_registers.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// ----------+-----------+-----------------------------------------------------
// s_axis    | in        | tuser: func; tdata: value, cycles
// m_axis    | out       | tdata: read_data, is_selected, is_enabled
//
// Each accepted transaction lands in an input register, is processed by the
// clock core once the output register is free and is captured there; one
// transaction per cycle is sustained while m_axis_tready_i stays high. A
// back-pressured master stalls the input side only once both registers are
// full. Reset (rst_ni low, asynchronous) empties both registers and restores
// the power-up clock: counters at zero, latched copy all ones.

module cartridge_rtc_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] value, [15:8] cycles
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [7:0] read_data, [8] is_selected,
                                       // [9] is_enabled, [15:10] zero
);

  logic             in_valid_q;
  crr_pkg::item_t   in_item_q;
  logic             out_valid_q;
  crr_pkg::result_t out_res_q;
  crr_pkg::result_t core_res;
  logic             out_free;
  logic             step;

  // The output slot is free when empty or being drained this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q.func   <= s_axis_tuser_i;
      in_item_q.value  <= s_axis_tdata_i[7:0];
      in_item_q.cycles <= s_axis_tdata_i[15:8];
    end
  end

  // The core commits its state update only when the transaction moves on.
  crr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_res_q};

endmodule
